// File: rtl/categorical_variance_split_search_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef CATEGORICAL_VARIANCE_SPLIT_SEARCH_MACROS_SVH
`define CATEGORICAL_VARIANCE_SPLIT_SEARCH_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define CVSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cvss check failed");
// Next-cycle implication.
`define CVSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cvss check failed");
`else
`define CVSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define CVSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/cvss_pkg.sv
`default_nettype none
package cvss_pkg;

    localparam int NCAT     = 16;
    localparam int CAT_W    = 4;
    localparam int TGT_W    = 16;
    localparam int CNT_W    = 13;
    localparam int SUM_W    = 28;
    localparam int SQ_W     = 44;
    localparam int IMP_W    = 30;
    localparam int COL_W    = 8;
    localparam int PROD_W   = 2 * SUM_W;
    localparam int XM_W     = SUM_W + CNT_W + 1;
    localparam int M_W      = CAT_W + 1;
    localparam logic [CNT_W-1:0] MAX_SAMPLES = CNT_W'(4096);
    localparam logic [IMP_W-1:0] IMP_MAX     = {IMP_W{1'b1}};

    localparam logic CFG_COLUMN_INDEX = 1'b0;
    localparam logic CFG_PRIOR_BEST   = 1'b1;

    typedef struct packed {
        logic [CAT_W-1:0]        category;
        logic signed [TGT_W-1:0] target_value;
        logic                    last_sample;
    } t_sample;

    typedef struct packed {
        logic                    split_found;
        logic [IMP_W-1:0]        best_impurity;
        logic signed [TGT_W-1:0] threshold_mean;
        logic [NCAT-1:0]         left_category_mask;
        logic [CNT_W-1:0]        left_count;
        logic [CNT_W-1:0]        right_count;
        logic [COL_W-1:0]        split_column;
        logic signed [TGT_W-1:0] node_mean;
        logic [IMP_W-1:0]        node_variance;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0]        cnt;
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sq;
    } t_cat_acc;

    typedef enum logic [4:0] {
        ST_ACC, ST_DRAIN, ST_NM_DIV, ST_NV_MUL, ST_NV_DIV1, ST_NV_DIV2,
        ST_RK_RDI, ST_RK_LATI, ST_RK_RDJ, ST_RK_MULJ, ST_RK_CMPJ, ST_RK_WR,
        ST_SW_INIT, ST_SW_RDO, ST_SW_RDC, ST_SW_ACC, ST_SW_MUL_L, ST_SW_DIV_L,
        ST_SW_MUL_R, ST_SW_DIV_R, ST_SW_DIV_S, ST_SW_CMP, ST_SW_THR, ST_OUT
    } t_state;

    function automatic logic [SUM_W-1:0] abs_sum(input logic signed [SUM_W-1:0] v);
        return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
    endfunction

    function automatic logic [SQ_W-1:0] sat_sub(input logic [SQ_W-1:0] a,
                                                  input logic [PROD_W-1:0] b);
        return (b > PROD_W'(a)) ? '0 : a - b[SQ_W-1:0];
    endfunction

    function automatic logic [IMP_W-1:0] sat_imp(input logic [PROD_W-1:0] q);
        return (q > PROD_W'(IMP_MAX)) ? IMP_MAX : q[IMP_W-1:0];
    endfunction

    // Floor of a signed quotient from the magnitude quotient and remainder.
    function automatic logic [TGT_W-1:0] floor_fix(input logic neg,
                                                    input logic [PROD_W-1:0] q,
                                                    input logic [CNT_W-1:0] rem);
        logic [TGT_W-1:0] qq;
        qq = q[TGT_W-1:0] + TGT_W'(rem != '0);
        return neg ? TGT_W'(-qq) : q[TGT_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/cvss_ram.sv
`default_nettype none
module cvss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/cvss_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module cvss_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [cvss_pkg::PROD_W-1:0]     i_num,
    input  wire logic [cvss_pkg::CNT_W-1:0]      i_den,
    output      logic                            o_done,
    output      logic [cvss_pkg::PROD_W-1:0]     o_quot,
    output      logic [cvss_pkg::CNT_W-1:0]      o_rem
);
    localparam int CW = $clog2(cvss_pkg::PROD_W);

    logic                           r_run;
    logic                           r_done;
    logic [CW-1:0]                  r_cnt;
    logic [cvss_pkg::PROD_W-1:0]    r_quot;
    logic [cvss_pkg::CNT_W-1:0]     r_rem;
    logic [cvss_pkg::CNT_W-1:0]     r_den;
    logic [cvss_pkg::CNT_W:0]       rem_sh;
    logic                           fits;

    assign rem_sh = {r_rem, r_quot[cvss_pkg::PROD_W-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(cvss_pkg::PROD_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
        end else if (r_run) begin
            r_quot <= {r_quot[cvss_pkg::PROD_W-2:0], fits};
            r_rem  <= fits ? cvss_pkg::CNT_W'(rem_sh - {1'b0, r_den})
                           : rem_sh[cvss_pkg::CNT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

// File: rtl/categorical_variance_split_search.sv
`default_nettype none
// Categorical split search for one regression-tree node. While o_busy is low the block
// takes one sample per cycle (i_start high) and folds it into a 16-entry accumulator
// RAM (count, sum, sum of squares per category) with a read-modify-write that forwards
// the previous cycle's write, so back-to-back samples of the same category are exact.
// A sample with last_sample set raises o_busy; the block then works out the node mean
// and variance, ranks the seen categories by mean (16 cross-multiplied compares per seen
// category), and sweeps the prefix splits. All divisions go through one shared
// restoring divider: 3 for the node, 3 or 4 per scored split. The result then appears
// on o_result, marked by o_done high for a single cycle; the receiver cannot stall it, so
// capture it then. An empty node skips straight from the drain cycle to the output.
// Configuration writes (i_cfg_we) take effect at once and belong to idle periods.
`include "categorical_variance_split_search_macros.svh"
module categorical_variance_split_search (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire cvss_pkg::t_sample           i_sample,
    output      logic                        o_busy,
    output      logic                        o_done,
    output      cvss_pkg::t_result           o_result,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_index,
    input  wire logic [cvss_pkg::IMP_W-1:0]  i_cfg_data
);
    localparam int ACC_W = $bits(cvss_pkg::t_cat_acc);
    localparam int CW    = cvss_pkg::CAT_W;

    cvss_pkg::t_state r_state, n_state;

    // Configuration
    logic [cvss_pkg::COL_W-1:0]        r_col;
    logic [cvss_pkg::IMP_W-1:0]        r_prior;

    // Node totals
    logic [cvss_pkg::CNT_W-1:0]        r_tot_n;
    logic signed [cvss_pkg::SUM_W-1:0] r_tot_s;
    logic [cvss_pkg::SQ_W-1:0]         r_tot_q;

    // Accumulate stage
    logic                              accept;
    logic                              r_s1_v;
    logic [CW-1:0]                     r_s1_cat;
    logic signed [cvss_pkg::TGT_W-1:0] r_s1_t;
    logic signed [2*cvss_pkg::TGT_W-1:0] t_prod;
    logic [cvss_pkg::SQ_W-1:0]         t_sq;
    logic                              r_wb_v;
    logic [CW-1:0]                     r_wb_cat;
    cvss_pkg::t_cat_acc                r_wb;
    cvss_pkg::t_cat_acc                s1_base, s1_new, acc_rd;
    logic [cvss_pkg::NCAT-1:0]         r_valid;

    // Memories
    logic [ACC_W-1:0]                  acc_rdata;
    logic [CW-1:0]                     acc_raddr;
    logic [CW-1:0]                     so_rdata;
    logic [CW-1:0]                     so_raddr;
    logic                              so_we;

    // Ranking
    logic [CW-1:0]                     r_i, r_j, r_rank, r_k;
    logic [cvss_pkg::M_W-1:0]          r_m;
    logic [cvss_pkg::CNT_W-1:0]        r_ci_cnt;
    logic signed [cvss_pkg::SUM_W-1:0] r_ci_sum;
    logic signed [cvss_pkg::XM_W-1:0]  r_x, r_y;

    // Sweep
    logic [cvss_pkg::CNT_W-1:0]        r_nl, r_nr, r_c_cnt;
    logic signed [cvss_pkg::SUM_W-1:0] r_sl, r_c_sum;
    logic [cvss_pkg::SQ_W-1:0]         r_ql, r_sse_l, r_sse_r;
    logic [cvss_pkg::NCAT-1:0]         r_mask;
    logic [CW-1:0]                     r_c;
    logic [cvss_pkg::PROD_W-1:0]       r_prod;
    logic [cvss_pkg::IMP_W-1:0]        r_score;
    logic [cvss_pkg::SUM_W-1:0]        abs_a;

    // Result fields
    logic [cvss_pkg::TGT_W-1:0]        r_mean, r_thr;
    logic [cvss_pkg::IMP_W-1:0]        r_nvar, r_best, nvar;
    logic                              r_found;
    logic [cvss_pkg::CNT_W-1:0]        r_bnl, r_bnr;
    logic [cvss_pkg::NCAT-1:0]         r_bmask;
    logic                              r_done;
    cvss_pkg::t_result                 r_res;

    // Divider
    logic                              r_div_run;
    logic                              div_state, div_start, div_done;
    logic [cvss_pkg::PROD_W-1:0]       div_num, div_quot;
    logic [cvss_pkg::CNT_W-1:0]        div_den, div_rem;
    logic                              more_splits;

    assign accept = i_start && !o_busy;
    assign o_busy = r_state != cvss_pkg::ST_ACC;
    assign o_done = r_done;
    assign o_result = r_res;

    // ---------------- accumulate: read at accept, modify and write in the next cycle
    assign acc_rd  = cvss_pkg::t_cat_acc'(acc_rdata);
    assign t_prod  = r_s1_t * r_s1_t;
    assign t_sq    = cvss_pkg::SQ_W'(t_prod[2*cvss_pkg::TGT_W-2:0]);

    always_comb begin
        if (r_wb_v && r_wb_cat == r_s1_cat) begin
            s1_base = r_wb;
        end else if (r_valid[r_s1_cat]) begin
            s1_base = acc_rd;
        end else begin
            s1_base = '0;
        end
        s1_new.cnt = s1_base.cnt + cvss_pkg::CNT_W'(1);
        s1_new.sum = s1_base.sum + cvss_pkg::SUM_W'(r_s1_t);
        s1_new.sq  = s1_base.sq + t_sq;
    end

    cvss_ram #(.WIDTH(ACC_W), .DEPTH(cvss_pkg::NCAT)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_v),
        .i_waddr (r_s1_cat),
        .i_wdata (ACC_W'(s1_new)),
        .i_raddr (acc_raddr),
        .o_rdata (acc_rdata)
    );

    cvss_ram #(.WIDTH(CW), .DEPTH(cvss_pkg::NCAT)) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (so_we),
        .i_waddr (r_rank),
        .i_wdata (r_i),
        .i_raddr (so_raddr),
        .o_rdata (so_rdata)
    );

    cvss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    assign nvar        = cvss_pkg::sat_imp(div_quot);
    assign more_splits = cvss_pkg::M_W'(r_k) + cvss_pkg::M_W'(2) < r_m;

    // ---------------- sequencer: next state, memory addresses, divider operands
    always_comb begin
        n_state   = r_state;
        acc_raddr = r_i;
        so_raddr  = r_k;
        so_we     = 1'b0;
        div_state = 1'b0;
        div_num   = r_prod;
        div_den   = r_tot_n;
        abs_a     = cvss_pkg::abs_sum(r_sl);
        case (r_state)
            cvss_pkg::ST_ACC: begin
                acc_raddr = i_sample.category;
                if (accept && i_sample.last_sample) begin
                    n_state = cvss_pkg::ST_DRAIN;
                end
            end
            cvss_pkg::ST_DRAIN: begin
                n_state = (r_tot_n == '0) ? cvss_pkg::ST_OUT : cvss_pkg::ST_NM_DIV;
            end
            cvss_pkg::ST_NM_DIV: begin
                div_state = 1'b1;
                div_num   = cvss_pkg::PROD_W'(cvss_pkg::abs_sum(r_tot_s));
                if (div_done) n_state = cvss_pkg::ST_NV_MUL;
            end
            cvss_pkg::ST_NV_MUL: begin
                n_state = cvss_pkg::ST_NV_DIV1;
            end
            cvss_pkg::ST_NV_DIV1: begin
                div_state = 1'b1;
                if (div_done) n_state = cvss_pkg::ST_NV_DIV2;
            end
            cvss_pkg::ST_NV_DIV2: begin
                div_state = 1'b1;
                div_num   = cvss_pkg::PROD_W'(r_sse_l);
                if (div_done) n_state = cvss_pkg::ST_RK_RDI;
            end
            cvss_pkg::ST_RK_RDI: begin
                if (r_valid[r_i]) begin
                    n_state = cvss_pkg::ST_RK_LATI;
                end else if (r_i == CW'(cvss_pkg::NCAT - 1)) begin
                    n_state = cvss_pkg::ST_SW_INIT;
                end
            end
            cvss_pkg::ST_RK_LATI: n_state = cvss_pkg::ST_RK_RDJ;
            cvss_pkg::ST_RK_RDJ: begin
                acc_raddr = r_j;
                n_state   = cvss_pkg::ST_RK_MULJ;
            end
            cvss_pkg::ST_RK_MULJ: n_state = cvss_pkg::ST_RK_CMPJ;
            cvss_pkg::ST_RK_CMPJ: begin
                n_state = (r_j == CW'(cvss_pkg::NCAT - 1)) ? cvss_pkg::ST_RK_WR
                                                          : cvss_pkg::ST_RK_RDJ;
            end
            cvss_pkg::ST_RK_WR: begin
                so_we   = 1'b1;
                n_state = (r_i == CW'(cvss_pkg::NCAT - 1)) ? cvss_pkg::ST_SW_INIT
                                                          : cvss_pkg::ST_RK_RDI;
            end
            cvss_pkg::ST_SW_INIT: begin
                n_state = (r_m < cvss_pkg::M_W'(2)) ? cvss_pkg::ST_OUT
                                                    : cvss_pkg::ST_SW_RDO;
            end
            cvss_pkg::ST_SW_RDO: n_state = cvss_pkg::ST_SW_RDC;
            cvss_pkg::ST_SW_RDC: begin
                acc_raddr = so_rdata;
                n_state   = cvss_pkg::ST_SW_ACC;
            end
            cvss_pkg::ST_SW_ACC: n_state = cvss_pkg::ST_SW_MUL_L;
            cvss_pkg::ST_SW_MUL_L: n_state = cvss_pkg::ST_SW_DIV_L;
            cvss_pkg::ST_SW_DIV_L: begin
                div_state = 1'b1;
                div_den   = r_nl;
                if (div_done) n_state = cvss_pkg::ST_SW_MUL_R;
            end
            cvss_pkg::ST_SW_MUL_R: begin
                abs_a   = cvss_pkg::abs_sum(r_tot_s - r_sl);
                n_state = cvss_pkg::ST_SW_DIV_R;
            end
            cvss_pkg::ST_SW_DIV_R: begin
                div_state = 1'b1;
                div_den   = r_nr;
                if (div_done) n_state = cvss_pkg::ST_SW_DIV_S;
            end
            cvss_pkg::ST_SW_DIV_S: begin
                div_state = 1'b1;
                div_num   = cvss_pkg::PROD_W'(r_sse_l) + cvss_pkg::PROD_W'(r_sse_r);
                if (div_done) n_state = cvss_pkg::ST_SW_CMP;
            end
            cvss_pkg::ST_SW_CMP: begin
                if (r_score < r_best) begin
                    n_state = cvss_pkg::ST_SW_THR;
                end else begin
                    n_state = more_splits ? cvss_pkg::ST_SW_RDO : cvss_pkg::ST_OUT;
                end
            end
            cvss_pkg::ST_SW_THR: begin
                div_state = 1'b1;
                div_num   = cvss_pkg::PROD_W'(cvss_pkg::abs_sum(r_c_sum));
                div_den   = r_c_cnt;
                if (div_done) begin
                    n_state = more_splits ? cvss_pkg::ST_SW_RDO : cvss_pkg::ST_OUT;
                end
            end
            cvss_pkg::ST_OUT: n_state = cvss_pkg::ST_ACC;
            default: n_state = cvss_pkg::ST_ACC;
        endcase
        div_start = div_state && !r_div_run;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cvss_pkg::ST_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_prior   <= cvss_pkg::IMP_MAX;
            r_tot_n   <= '0;
            r_s1_v    <= 1'b0;
            r_wb_v    <= 1'b0;
            r_valid   <= '0;
            r_div_run <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    cvss_pkg::CFG_COLUMN_INDEX: r_col <= i_cfg_data[cvss_pkg::COL_W-1:0];
                    cvss_pkg::CFG_PRIOR_BEST:   r_prior <= i_cfg_data;
                    default: ;
                endcase
            end
            // Drop samples past the node's sample limit, but still honor last.
            r_s1_v <= accept && (r_tot_n < cvss_pkg::MAX_SAMPLES);
            if (accept && r_tot_n < cvss_pkg::MAX_SAMPLES) begin
                r_tot_n <= r_tot_n + cvss_pkg::CNT_W'(1);
            end
            r_wb_v <= r_s1_v;
            if (r_s1_v) begin
                r_valid[r_s1_cat] <= 1'b1;
            end
            if (div_start) begin
                r_div_run <= 1'b1;
            end else if (div_done) begin
                r_div_run <= 1'b0;
            end
            r_done <= r_state == cvss_pkg::ST_OUT;
            if (r_state == cvss_pkg::ST_OUT) begin
                r_tot_n <= '0;
                r_valid <= '0;
            end
        end
    end

    // ---------------- datapath
    always_ff @(posedge i_clk) begin
        r_s1_cat <= i_sample.category;
        r_s1_t   <= i_sample.target_value;
        if (r_s1_v) begin
            r_wb     <= s1_new;
            r_wb_cat <= r_s1_cat;
        end
        // Node totals start from zero after reset.
        if (!i_rst_n) begin
            r_tot_s <= '0;
            r_tot_q <= '0;
        end else if (r_s1_v) begin
            r_tot_s <= r_tot_s + cvss_pkg::SUM_W'(r_s1_t);
            r_tot_q <= r_tot_q + t_sq;
        end
        case (r_state)
            cvss_pkg::ST_DRAIN: begin
                r_mean  <= '0;
                r_nvar  <= '0;
                r_best  <= '0;
                r_found <= 1'b0;
                r_thr   <= '0;
                r_bmask <= '0;
                r_bnl   <= '0;
                r_bnr   <= '0;
            end
            cvss_pkg::ST_NM_DIV: begin
                if (div_done) begin
                    r_mean <= cvss_pkg::floor_fix(r_tot_s[cvss_pkg::SUM_W-1], div_quot,
                                                  div_rem);
                end
            end
            cvss_pkg::ST_NV_MUL: begin
                r_prod <= cvss_pkg::PROD_W'(cvss_pkg::abs_sum(r_tot_s))
                          * cvss_pkg::PROD_W'(cvss_pkg::abs_sum(r_tot_s));
            end
            cvss_pkg::ST_NV_DIV1: begin
                if (div_done) r_sse_l <= cvss_pkg::sat_sub(r_tot_q, div_quot);
            end
            cvss_pkg::ST_NV_DIV2: begin
                if (div_done) begin
                    r_nvar <= nvar;
                    r_best <= (nvar < r_prior) ? nvar : r_prior;
                    r_i    <= '0;
                    r_m    <= '0;
                end
            end
            cvss_pkg::ST_RK_RDI: begin
                if (!r_valid[r_i] && r_i != CW'(cvss_pkg::NCAT - 1)) begin
                    r_i <= r_i + CW'(1);
                end
            end
            cvss_pkg::ST_RK_LATI: begin
                r_ci_cnt <= acc_rd.cnt;
                r_ci_sum <= acc_rd.sum;
                r_j      <= '0;
                r_rank   <= '0;
            end
            cvss_pkg::ST_RK_MULJ: begin
                // Compare means without dividing: sum_j * n_i against sum_i * n_j.
                r_x <= acc_rd.sum * $signed({1'b0, r_ci_cnt});
                r_y <= r_ci_sum * $signed({1'b0, acc_rd.cnt});
            end
            cvss_pkg::ST_RK_CMPJ: begin
                if (r_valid[r_j] && (r_x < r_y || (r_x == r_y && r_j < r_i))) begin
                    r_rank <= r_rank + CW'(1);
                end
                r_j <= r_j + CW'(1);
            end
            cvss_pkg::ST_RK_WR: begin
                r_m <= r_m + cvss_pkg::M_W'(1);
                r_i <= r_i + CW'(1);
            end
            cvss_pkg::ST_SW_INIT: begin
                r_k    <= '0;
                r_nl   <= '0;
                r_sl   <= '0;
                r_ql   <= '0;
                r_mask <= '0;
            end
            cvss_pkg::ST_SW_RDC: begin
                r_c <= so_rdata;
            end
            cvss_pkg::ST_SW_ACC: begin
                r_nl      <= r_nl + acc_rd.cnt;
                r_sl      <= r_sl + acc_rd.sum;
                r_ql      <= r_ql + acc_rd.sq;
                r_mask[r_c] <= 1'b1;
                r_c_cnt   <= acc_rd.cnt;
                r_c_sum   <= acc_rd.sum;
            end
            cvss_pkg::ST_SW_MUL_L: begin
                r_prod <= cvss_pkg::PROD_W'(abs_a) * cvss_pkg::PROD_W'(abs_a);
                r_nr   <= r_tot_n - r_nl;
            end
            cvss_pkg::ST_SW_DIV_L: begin
                if (div_done) r_sse_l <= cvss_pkg::sat_sub(r_ql, div_quot);
            end
            cvss_pkg::ST_SW_MUL_R: begin
                r_prod <= cvss_pkg::PROD_W'(abs_a) * cvss_pkg::PROD_W'(abs_a);
            end
            cvss_pkg::ST_SW_DIV_R: begin
                if (div_done) r_sse_r <= cvss_pkg::sat_sub(r_tot_q - r_ql, div_quot);
            end
            cvss_pkg::ST_SW_DIV_S: begin
                if (div_done) r_score <= nvar;
            end
            cvss_pkg::ST_SW_CMP: begin
                if (r_score < r_best) begin
                    r_best  <= r_score;
                    r_found <= 1'b1;
                    r_bnl   <= r_nl;
                    r_bnr   <= r_nr;
                    r_bmask <= r_mask;
                end else begin
                    r_k <= r_k + CW'(1);
                end
            end
            cvss_pkg::ST_SW_THR: begin
                if (div_done) begin
                    r_thr <= cvss_pkg::floor_fix(r_c_sum[cvss_pkg::SUM_W-1], div_quot,
                                                 div_rem);
                    r_k   <= r_k + CW'(1);
                end
            end
            cvss_pkg::ST_OUT: begin
                r_res.split_found        <= r_found;
                r_res.best_impurity      <= r_best;
                r_res.threshold_mean     <= r_thr;
                r_res.left_category_mask <= r_bmask;
                r_res.left_count         <= r_bnl;
                r_res.right_count        <= r_bnr;
                r_res.split_column       <= r_col;
                r_res.node_mean          <= r_mean;
                r_res.node_variance      <= r_nvar;
                r_tot_s                  <= '0;
                r_tot_q                  <= '0;
            end
            default: ;
        endcase
    end

    // ---------------- checks
    `CVSS_ASSERT_NEXT(a_single_result, i_clk, i_rst_n, o_done, !o_done)
    `CVSS_ASSERT_NOW(a_acc_write_window, i_clk, i_rst_n, r_s1_v,
        r_state == cvss_pkg::ST_ACC || r_state == cvss_pkg::ST_DRAIN)
    `CVSS_ASSERT_NOW(a_found_beats_var, i_clk, i_rst_n, o_done && o_result.split_found,
        o_result.best_impurity < o_result.node_variance)
    `CVSS_ASSERT_NOW(a_no_split_empty, i_clk, i_rst_n, o_done && !o_result.split_found,
        o_result.left_category_mask == '0 && o_result.left_count == '0)

endmodule
`default_nettype wire
